// ===== sv/bth_pkg.sv =====
// Shared constants, types and helpers for the boundary-tag heap allocator.
// No dependencies; the top level, the sequencer and the testbench import this package.
package bth_pkg;

  localparam int HEAP_BYTES    = 65536;
  localparam int PAGE_BYTES    = 4096;
  localparam int INITIAL_BYTES = 4096;

  localparam int STORE_WORDS = HEAP_BYTES / 4;
  localparam int WIDX_W      = $clog2(STORE_WORDS);
  // byte addresses carry headroom so that underflow lands far outside the store
  localparam int A_W         = $clog2(HEAP_BYTES) + 4;
  localparam int TAG_W       = 17;
  localparam int LIMIT_W     = 17;
  localparam int REQ_W       = 16;
  localparam int OFF_W       = 16;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'h10000;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] STAT_DONE = 2'd0;
  localparam logic [1:0] STAT_NULL = 2'd1;
  localparam logic [1:0] STAT_OOM  = 2'd2;

  function automatic int align8_f(int s);
    return ((s + 7) >> 3) << 3;
  endfunction

  localparam int INIT_SIZE     = (align8_f(INITIAL_BYTES) < 16) ? 16 : align8_f(INITIAL_BYTES);
  localparam int PAGE_AL       = align8_f(PAGE_BYTES);
  localparam int LIM_RESET_EFF = (65536 > HEAP_BYTES) ? HEAP_BYTES : 65536;
  localparam int INIT_END      = 16 + INIT_SIZE;

  // page mapping done at reset; stops at the first page over the ceiling
  function automatic int init_map_f(int end_b, int lim);
    int m;
    m = PAGE_BYTES;
    while (m < end_b) begin
      if (m + PAGE_BYTES > lim) return m;
      m = m + PAGE_BYTES;
    end
    return m;
  endfunction

  localparam int INIT_MAPPED = init_map_f(INIT_END, LIM_RESET_EFF);
  localparam bit INIT_FITS   = (INIT_MAPPED >= INIT_END);
  localparam int INIT_BRK    = INIT_FITS ? (12 + INIT_SIZE) : 12;
  localparam int PRO_TAG     = 9;

  // block size field of a tag, widened to a byte address
  function automatic logic [A_W-1:0] tsz_f(logic [TAG_W-1:0] w);
    return {{(A_W-TAG_W){1'b0}}, w[TAG_W-1:3], 3'b000};
  endfunction

  typedef struct packed {
    logic              valid;
    logic [1:0]        status;
    logic [OFF_W-1:0]  payload;
  } bth_res_t;

  typedef struct packed {
    logic              we;
    logic [WIDX_W-1:0] waddr;
    logic [TAG_W-1:0]  wdata;
    logic [WIDX_W-1:0] raddr;
  } bth_mem_req_t;

endpackage

// ===== sv/bth_if.sv =====
// Channel interfaces of the allocator: command, response and limit write.
// Widths follow the fixed field widths; no package dependency.
interface bth_cmd_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [15:0] request_bytes;
  logic [15:0] block_offset;
  modport source(output valid, opcode, request_bytes, block_offset, input ready);
  modport sink(input valid, opcode, request_bytes, block_offset, output ready);
endinterface

interface bth_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] payload_offset;
  modport source(output valid, status, payload_offset, input ready);
  modport sink(input valid, status, payload_offset, output ready);
endinterface

interface bth_cfg_if;
  logic        valid;
  logic        ready;
  logic [16:0] heap_limit_bytes;
  modport source(output valid, heap_limit_bytes, input ready);
  modport sink(input valid, heap_limit_bytes, output ready);
endinterface

// ===== sv/boundary_tag_heap_allocator.sv =====
// Top level of the boundary-tag heap allocator.
// Depends on bth_pkg, bth_if, bth_ram and bth_seq.
//
// One command at a time. After reset the tag store (one word per 4 heap bytes)
// is swept once, one word a cycle, to lay down the prologue, the first free
// block and the epilogue; cmd.ready stays low meanwhile, limit writes are
// taken throughout. Null requests go straight to the response. Allocate steps
// past the prologue, then walks the blocks for the first fit (one tag read per
// cycle from the single read port of the store), then places, splits and hands
// over. A walk that falls off the end instead grows the heap: it maps pages
// (out of memory past the limit), writes the new block's tags and merges, then
// places. Free clears the allocated bit and merges with free neighbors.
// Each result sits in an output register, so a new command is taken while the
// previous response waits. The limit register is taken any cycle and should
// only be written with no command in flight.
module boundary_tag_heap_allocator (
  input  logic      clk,
  input  logic      rst,
  bth_cmd_if.sink   cmd,
  bth_rsp_if.source rsp,
  bth_cfg_if.sink   cfg
);
  import bth_pkg::*;

  logic [LIMIT_W-1:0] heap_limit;
  bth_res_t           res;
  bth_mem_req_t       mem;
  logic [TAG_W-1:0]   mem_rdata;
  logic               res_take;

  // limit register: values above the store size are clamped in the sequencer
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_limit <= LIMIT_RESET;
    end else if (cfg.valid) begin
      heap_limit <= cfg.heap_limit_bytes;
    end
  end

  bth_ram #(
    .WIDTH (TAG_W),
    .DEPTH (STORE_WORDS)
  ) u_tags (
    .clk   (clk),
    .we    (mem.we),
    .waddr (mem.waddr),
    .wdata (mem.wdata),
    .raddr (mem.raddr),
    .rdata (mem_rdata)
  );

  bth_seq u_seq (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .heap_limit_bytes (heap_limit),
    .res              (res),
    .res_take         (res_take),
    .mem              (mem),
    .mem_rdata        (mem_rdata)
  );

  // response register: loads when empty or when the held beat leaves
  assign res_take = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res.valid && res_take) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_take) begin
      rsp.status         <= res.status;
      rsp.payload_offset <= res.payload;
    end
  end

endmodule

// ===== sv/bth_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module bth_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata <= mem_q[raddr];
  end

endmodule

// ===== sv/bth_seq.sv =====
// Tag store sequencer: clearing pass, first-fit walk, heap growth, merge, split.
// Depends on bth_pkg and bth_cmd_if; drives one port pair of the tag RAM.
module bth_seq (
  input  logic                         clk,
  input  logic                         rst,
  bth_cmd_if.sink                      cmd,
  input  logic [bth_pkg::LIMIT_W-1:0]  heap_limit_bytes,
  output bth_pkg::bth_res_t            res,
  input  logic                         res_take,
  output bth_pkg::bth_mem_req_t        mem,
  input  logic [bth_pkg::TAG_W-1:0]    mem_rdata
);
  import bth_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_A0, S_A1, S_WALK, S_MAP, S_G1, S_G2, S_G3, S_G4,
    S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_MW2, S_P0, S_P1,
    S_SW, S_SR, S_SF, S_F0, S_F1, S_FIN
  } state_t;

  typedef enum logic [1:0] {K_REM, K_PDONE, K_MEND, K_FREE} cont_t;

  localparam logic [A_W-1:0]    HEAP_A   = A_W'(HEAP_BYTES);
  localparam logic [A_W-1:0]    PAGE_A   = A_W'(PAGE_BYTES);
  localparam logic [TAG_W-1:0]  PAGE_T   = TAG_W'(PAGE_AL);
  localparam logic [WIDX_W-1:0] LAST_IDX = WIDX_W'(STORE_WORDS - 1);
  localparam logic [WIDX_W-1:0] IDX_FTR0 = WIDX_W'((8 + INIT_SIZE) / 4);
  localparam logic [WIDX_W-1:0] IDX_EPI  = WIDX_W'((12 + INIT_SIZE) / 4);

  state_t            state;
  cont_t             cont;
  logic [WIDX_W-1:0] cnt;
  logic              is_alloc;
  logic [A_W-1:0]    bp, pb, nb, wa, base, brk, mapped, endr;
  logic [TAG_W-1:0]  asize, ext, val, dval, pbsz, szb;
  logic              pfree;
  logic              rd_oob;
  logic [1:0]        res_status;
  logic [OFF_W-1:0]  res_payload;

  logic [A_W-1:0]    rd_addr, wr_addr, lim, v_sz;
  logic              wr_en;
  logic [TAG_W-1:0]  wr_data, v, clr_data, asize_c, ext_c, cs, nbsz;
  logic [TAG_W:0]    diff;

  // read data of the previous cycle; out-of-store reads give zero
  assign v    = rd_oob ? '0 : mem_rdata;
  assign v_sz = tsz_f(v);
  assign lim  = (A_W'(heap_limit_bytes) > HEAP_A) ? HEAP_A : A_W'(heap_limit_bytes);

  assign asize_c = (TAG_W'({1'b0, cmd.request_bytes} + 17'd7) & ~TAG_W'(7)) + TAG_W'(8);
  assign ext_c   = (asize > PAGE_T) ? asize : PAGE_T;
  assign cs      = {v[TAG_W-1:3], 3'b000};
  assign nbsz    = {v[TAG_W-1:3], 3'b000};
  assign diff    = {1'b0, cs} - {1'b0, asize};

  assign cmd.ready   = (state == S_IDLE);
  assign res.valid   = (state == S_FIN);
  assign res.status  = res_status;
  assign res.payload = res_payload;

  // reset image of the store
  always_comb begin
    clr_data = '0;
    if (cnt == WIDX_W'(1) || cnt == WIDX_W'(2)) clr_data = TAG_W'(PRO_TAG);
    if (INIT_FITS) begin
      if (cnt == WIDX_W'(3) || cnt == IDX_FTR0) clr_data = TAG_W'(INIT_SIZE);
      if (cnt == IDX_EPI) clr_data = TAG_W'(1);
    end else if (cnt == WIDX_W'(3)) begin
      clr_data = TAG_W'(1);
    end
  end

  always_comb begin
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    unique case (state)
      // walk starts past the prologue, whose header gives its size
      S_A0:   rd_addr = A_W'(4);
      S_A1:   rd_addr = bp + v_sz - A_W'(4);
      S_WALK: rd_addr = bp + v_sz - A_W'(4);
      S_G1:   begin wr_en = 1'b1; wr_addr = brk; wr_data = ext; end
      S_G2:   rd_addr = bp - A_W'(4);
      S_G3:   begin wr_en = 1'b1; wr_addr = bp + v_sz - A_W'(8); wr_data = ext; end
      S_G4:   begin wr_en = 1'b1; wr_addr = nb - A_W'(4); wr_data = TAG_W'(1); end
      S_M0:   rd_addr = bp - A_W'(8);
      S_M1:   rd_addr = bp - v_sz - A_W'(4);
      S_M2:   rd_addr = pb + v_sz - A_W'(8);
      S_M3:   rd_addr = bp - A_W'(4);
      S_M4:   rd_addr = bp + v_sz - A_W'(4);
      S_M5: begin
        // free predecessor, allocated successor: footer of this block first
        if (pfree && v[0]) begin
          wr_en   = 1'b1;
          wr_addr = bp + A_W'(szb) - A_W'(8);
          wr_data = szb + pbsz;
        end
      end
      S_MW2:  begin wr_en = 1'b1; wr_addr = wa; wr_data = val; end
      S_P0:   rd_addr = bp - A_W'(4);
      S_SW:   begin wr_en = 1'b1; wr_addr = wa; wr_data = val; end
      S_SR:   rd_addr = base - A_W'(4);
      S_SF:   begin wr_en = 1'b1; wr_addr = base + v_sz - A_W'(8); wr_data = val; end
      S_F0:   rd_addr = bp - A_W'(4);
      default: ;
    endcase
  end

  always_comb begin
    if (state == S_CLEAR) begin
      mem.we    = 1'b1;
      mem.waddr = cnt;
      mem.wdata = clr_data;
    end else begin
      mem.we    = wr_en && (wr_addr < HEAP_A);
      mem.waddr = wr_addr[WIDX_W+1:2];
      mem.wdata = wr_data;
    end
    mem.raddr = rd_addr[WIDX_W+1:2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      cnt         <= '0;
      mapped      <= A_W'(INIT_MAPPED);
      brk         <= A_W'(INIT_BRK);
      rd_oob      <= 1'b0;
      res_status  <= STAT_DONE;
      res_payload <= '0;
    end else begin
      rd_oob <= !(rd_addr < HEAP_A);
      unique case (state)
        S_CLEAR: begin
          cnt <= cnt + WIDX_W'(1);
          if (cnt == LAST_IDX) state <= S_IDLE;
        end
        S_IDLE: begin
          if (cmd.valid) begin
            is_alloc <= (cmd.opcode == OP_ALLOC);
            if (cmd.opcode == OP_ALLOC) begin
              if (cmd.request_bytes == '0) begin
                res_status  <= STAT_NULL;
                res_payload <= '0;
                state       <= S_FIN;
              end else begin
                asize <= asize_c;
                bp    <= A_W'(8);
                state <= S_A0;
              end
            end else if (cmd.block_offset == '0) begin
              res_status  <= STAT_NULL;
              res_payload <= '0;
              state       <= S_FIN;
            end else begin
              bp    <= A_W'(cmd.block_offset);
              state <= S_F0;
            end
          end
        end
        S_A0: state <= S_A1;
        S_A1: begin
          bp    <= bp + v_sz;
          state <= S_WALK;
        end
        S_WALK: begin
          priority if (v_sz == '0) begin
            ext   <= ext_c;
            endr  <= brk + A_W'(ext_c) + A_W'(4);
            state <= S_MAP;
          end else if (!v[0] && v_sz >= A_W'(asize)) begin
            state <= S_P0;
          end else begin
            bp <= bp + v_sz;
          end
        end
        S_MAP: begin
          if (mapped < endr) begin
            if (mapped + PAGE_A > lim) begin
              res_status  <= STAT_OOM;
              res_payload <= '0;
              state       <= S_FIN;
            end else begin
              mapped <= mapped + PAGE_A;
            end
          end else begin
            state <= S_G1;
          end
        end
        S_G1: begin bp <= brk + A_W'(4); state <= S_G2; end
        S_G2: state <= S_G3;
        S_G3: begin nb <= bp + v_sz; state <= S_G4; end
        S_G4: begin brk <= brk + A_W'(ext); state <= S_M0; end
        S_M0: state <= S_M1;
        S_M1: begin pb <= bp - v_sz; state <= S_M2; end
        S_M2: begin pbsz <= {v[TAG_W-1:3], 3'b000}; state <= S_M3; end
        S_M3: begin pfree <= !v[0]; state <= S_M4; end
        S_M4: begin
          szb   <= {v[TAG_W-1:3], 3'b000};
          nb    <= bp + v_sz;
          state <= S_M5;
        end
        S_M5: begin
          priority if (!pfree && v[0]) begin
            if (is_alloc) state <= S_P0;
            else begin
              res_status  <= STAT_DONE;
              res_payload <= '0;
              state       <= S_FIN;
            end
          end else if (!pfree) begin
            val   <= szb + nbsz;
            wa    <= bp - A_W'(4);
            base  <= bp;
            cont  <= K_MEND;
            state <= S_SW;
          end else if (v[0]) begin
            val   <= szb + pbsz;
            wa    <= pb - A_W'(4);
            bp    <= pb;
            state <= S_MW2;
          end else begin
            val   <= szb + pbsz + nbsz;
            wa    <= pb - A_W'(4);
            base  <= nb;
            bp    <= pb;
            cont  <= K_MEND;
            state <= S_SW;
          end
        end
        S_MW2: begin
          if (is_alloc) state <= S_P0;
          else begin
            res_status  <= STAT_DONE;
            res_payload <= '0;
            state       <= S_FIN;
          end
        end
        S_P0: state <= S_P1;
        S_P1: begin
          wa   <= bp - A_W'(4);
          base <= bp;
          if (diff[TAG_W] || diff[TAG_W-1:0] >= TAG_W'(16)) begin
            val  <= {asize[TAG_W-1:1], 1'b1};
            dval <= diff[TAG_W-1:0];
            cont <= K_REM;
          end else begin
            val  <= {cs[TAG_W-1:1], 1'b1};
            cont <= K_PDONE;
          end
          state <= S_SW;
        end
        S_SW: state <= S_SR;
        S_SR: state <= S_SF;
        S_SF: begin
          unique case (cont)
            K_REM: begin
              wa    <= base + v_sz - A_W'(4);
              base  <= base + v_sz;
              val   <= dval;
              cont  <= K_PDONE;
              state <= S_SW;
            end
            K_PDONE: begin
              res_status  <= STAT_DONE;
              res_payload <= bp[OFF_W-1:0];
              state       <= S_FIN;
            end
            K_MEND: begin
              if (is_alloc) state <= S_P0;
              else begin
                res_status  <= STAT_DONE;
                res_payload <= '0;
                state       <= S_FIN;
              end
            end
            K_FREE: state <= S_M0;
            default: state <= S_FIN;
          endcase
        end
        S_F0: state <= S_F1;
        S_F1: begin
          wa    <= bp - A_W'(4);
          base  <= bp;
          val   <= {v[TAG_W-1:3], 3'b000};
          cont  <= K_FREE;
          state <= S_SW;
        end
        S_FIN: if (res_take) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== verif/boundary_tag_heap_allocator_tb.sv =====
// Self-checking testbench for boundary_tag_heap_allocator: a clocked driver and
// monitor with a built-in heap predictor. Depends on bth_pkg, bth_if and the RTL.
module boundary_tag_heap_allocator_tb;
  import bth_pkg::*;

  typedef struct {
    logic        op;
    logic [15:0] req;
    logic [15:0] off;
  } heap_cmd_t;

  typedef struct {
    logic [1:0]  status;
    logic [15:0] payload;
  } heap_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bth_cmd_if cmd_ch();
  bth_rsp_if rsp_ch();
  bth_cfg_if cfg_ch();

  boundary_tag_heap_allocator u_top (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch.sink),
    .rsp(rsp_ch.source),
    .cfg(cfg_ch.sink)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Heap predictor: its own copy of the tag store, break, mapped pages, limit.
  // Byte addresses are signed 64-bit; anything outside the store reads 0 and
  // swallows writes, which also covers underflow on corrupted walks.
  // ---------------------------------------------------------------------------
  logic [TAG_W-1:0] heap_tags [STORE_WORDS];
  longint           heap_break;
  longint           heap_mapped;
  longint           heap_limit;

  function automatic int unsigned tag_rd(longint a);
    if (a < 0 || (a >> 2) >= STORE_WORDS) return 0;
    return heap_tags[a >> 2];
  endfunction

  function automatic void tag_wr(longint a, int unsigned v);
    if (a >= 0 && (a >> 2) < STORE_WORDS) heap_tags[a >> 2] = v[TAG_W-1:0];
  endfunction

  function automatic longint blk_size(longint a);
    return longint'(tag_rd(a) & ~32'h7);
  endfunction

  function automatic bit blk_used(longint a);
    return 1'(tag_rd(a) & 32'h1);
  endfunction

  function automatic longint hdr_of(longint bp);
    return bp - 4;
  endfunction

  function automatic longint ftr_of(longint bp);
    return bp + blk_size(bp - 4) - 8;
  endfunction

  function automatic longint next_of(longint bp);
    return bp + blk_size(bp - 4);
  endfunction

  function automatic longint rnd8(longint s);
    return (s + 7) & ~longint'(7);
  endfunction

  function automatic bit map_pages(longint upto);
    longint lim;
    lim = (heap_limit > HEAP_BYTES) ? HEAP_BYTES : heap_limit;
    while (heap_mapped < upto) begin
      if (heap_mapped + PAGE_BYTES > lim) return 1'b0;
      heap_mapped += PAGE_BYTES;
    end
    return 1'b1;
  endfunction

  // coalesce with free neighbors; four cases by which side is free
  function automatic longint coalesce(longint bp);
    longint      pb, nb;
    bit          pfree, nfree;
    int unsigned sz;
    pb = bp - blk_size(bp - 8);
    nb = next_of(bp);
    pfree = !blk_used(ftr_of(pb));
    nfree = !blk_used(hdr_of(nb));
    sz = int'(blk_size(hdr_of(bp)));
    if (!pfree && !nfree) return bp;
    if (!pfree) begin
      sz += int'(blk_size(hdr_of(nb)));
      tag_wr(hdr_of(bp), sz);
      tag_wr(ftr_of(bp), sz);
      return bp;
    end
    if (!nfree) begin
      sz += int'(blk_size(hdr_of(pb)));
      tag_wr(ftr_of(bp), sz);
      tag_wr(hdr_of(pb), sz);
      return pb;
    end
    sz += int'(blk_size(hdr_of(pb))) + int'(blk_size(hdr_of(nb)));
    tag_wr(hdr_of(pb), sz);
    tag_wr(ftr_of(nb), sz);
    return pb;
  endfunction

  function automatic bit grow_heap(longint size, output longint bp);
    bp = 0;
    if (!map_pages(heap_break + size + 4)) return 1'b0;
    bp = heap_break + 4;
    tag_wr(heap_break, int'(size));
    tag_wr(ftr_of(bp), int'(size));
    tag_wr(hdr_of(next_of(bp)), 1);
    heap_break += size;
    bp = coalesce(bp);
    return 1'b1;
  endfunction

  function automatic void carve(longint bp, longint asize);
    int unsigned cs, as, rest;
    longint      rem;
    cs = int'(blk_size(hdr_of(bp)));
    as = int'(asize);
    rest = cs - as;
    if (rest >= 16) begin
      tag_wr(hdr_of(bp), as | 1);
      tag_wr(ftr_of(bp), as | 1);
      rem = next_of(bp);
      tag_wr(hdr_of(rem), rest);
      tag_wr(ftr_of(rem), rest);
    end else begin
      tag_wr(hdr_of(bp), cs | 1);
      tag_wr(ftr_of(bp), cs | 1);
    end
  endfunction

  function automatic void heap_init();
    longint bp;
    bit     ok;
    foreach (heap_tags[i]) heap_tags[i] = '0;
    heap_limit = LIMIT_RESET;
    heap_mapped = PAGE_BYTES;
    tag_wr(4, 9);
    tag_wr(8, 9);
    tag_wr(12, 1);
    heap_break = 12;
    ok = grow_heap((rnd8(INITIAL_BYTES) < 16) ? 16 : rnd8(INITIAL_BYTES), bp);
  endfunction

  function automatic heap_rsp_t heap_step(heap_cmd_t c);
    heap_rsp_t   r;
    longint      asize, bp, ext;
    int unsigned sz;
    r.status = STAT_DONE;
    r.payload = '0;
    if (c.op == OP_ALLOC) begin
      if (c.req == 0) begin
        r.status = STAT_NULL;
        return r;
      end
      asize = rnd8(c.req) + 8;
      if (asize < 16) asize = 16;
      for (bp = next_of(8); blk_size(hdr_of(bp)) > 0; bp = next_of(bp)) begin
        if (!blk_used(hdr_of(bp)) && blk_size(hdr_of(bp)) >= asize) begin
          carve(bp, asize);
          r.payload = bp[15:0];
          return r;
        end
      end
      ext = rnd8((asize > PAGE_BYTES) ? asize : PAGE_BYTES);
      if (!grow_heap(ext, bp)) begin
        r.status = STAT_OOM;
        return r;
      end
      carve(bp, asize);
      r.payload = bp[15:0];
      return r;
    end
    if (c.off == 0) begin
      r.status = STAT_NULL;
      return r;
    end
    sz = int'(blk_size(hdr_of(c.off)));
    tag_wr(hdr_of(c.off), sz);
    tag_wr(ftr_of(c.off), sz);
    bp = coalesce(c.off);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver, monitor and scoreboard state
  // ---------------------------------------------------------------------------
  heap_cmd_t   pending_cmds[$];
  heap_rsp_t   expected_rsps[$];
  logic [15:0] live_blocks[$];   // payload offsets believed allocated
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          failed = 1'b0;

  initial begin
    cmd_ch.valid = 1'b0;
    cmd_ch.opcode = OP_ALLOC;
    cmd_ch.request_bytes = '0;
    cmd_ch.block_offset = '0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.heap_limit_bytes = LIMIT_RESET;
    heap_init();
  end

  // command driver: holds a beat until taken, then maybe idles
  always @(posedge clk) begin
    if (!rst && (!cmd_ch.valid || cmd_ch.ready)) begin
      if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        cmd_ch.valid <= 1'b1;
        cmd_ch.opcode <= pending_cmds[0].op;
        cmd_ch.request_bytes <= pending_cmds[0].req;
        cmd_ch.block_offset <= pending_cmds[0].off;
        void'(pending_cmds.pop_front());
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  // response back-pressure
  always @(posedge clk) begin
    rsp_ch.ready <= !rst && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // accepted command beat -> predicted response
  always @(posedge clk) begin
    heap_cmd_t c;
    heap_rsp_t r;
    if (!rst && cmd_ch.valid && cmd_ch.ready) begin
      c.op = cmd_ch.opcode;
      c.req = cmd_ch.request_bytes;
      c.off = cmd_ch.block_offset;
      r = heap_step(c);
      expected_rsps.push_back(r);
      if (c.op == OP_ALLOC && r.status == STAT_DONE) live_blocks.push_back(r.payload);
    end
  end

  // response beat checker
  always @(posedge clk) begin
    heap_rsp_t e;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_rsps.size() == 0) begin
        $error("unexpected response beat: status %0d payload_offset %0d",
               rsp_ch.status, rsp_ch.payload_offset);
        failed = 1'b1;
      end else begin
        e = expected_rsps.pop_front();
        if (rsp_ch.status !== e.status) begin
          $error("status: expected %0d actual %0d", e.status, rsp_ch.status);
          failed = 1'b1;
        end
        if (rsp_ch.payload_offset !== e.payload) begin
          $error("payload_offset: expected %0d actual %0d", e.payload,
                 rsp_ch.payload_offset);
          failed = 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic push_alloc(int req);
    heap_cmd_t c;
    c.op = OP_ALLOC;
    c.req = req[15:0];
    c.off = 16'($urandom);   // ignored on allocate, toggles the field
    pending_cmds.push_back(c);
  endtask

  task automatic push_free(logic [15:0] off);
    heap_cmd_t c;
    c.op = OP_FREE;
    c.req = 16'($urandom);   // ignored on free
    c.off = off;
    pending_cmds.push_back(c);
  endtask

  // wait until nothing is queued, on the wire, or owed
  task automatic drain();
    do @(posedge clk);
    while (pending_cmds.size() != 0 || cmd_ch.valid || expected_rsps.size() != 0);
  endtask

  task automatic write_limit(logic [16:0] lim);
    drain();
    repeat (40) @(posedge clk);
    cfg_ch.heap_limit_bytes <= lim;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ch.ready);
    heap_limit = lim;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_items(int n);
    int sel;
    int req;
    int k;
    for (int i = 0; i < n; i++) begin
      while (pending_cmds.size() != 0) @(posedge clk);
      sel = $urandom_range(0, 99);
      if (sel < 55 || live_blocks.size() == 0) begin
        sel = $urandom_range(0, 99);
        if (sel < 2)       req = 0;
        else if (sel < 60) req = $urandom_range(1, 64);
        else if (sel < 85) req = $urandom_range(65, 1024);
        else if (sel < 96) req = $urandom_range(1025, 8192);
        else               req = $urandom_range(8193, 65535);
        push_alloc(req);
      end else if (sel < 98) begin
        k = $urandom_range(0, live_blocks.size() - 1);
        push_free(live_blocks[k]);
        live_blocks.delete(k);
      end else begin
        push_free(16'h0);
      end
    end
  endtask

  initial begin
    logic [15:0] blk[$];
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, null requests, every merge case, bogus frees
    send_idle_pct = 14;
    recv_stall_pct = 57;
    push_alloc(0);
    push_free(16'h0);
    push_alloc(1);
    push_alloc(8);
    push_alloc(9);
    push_alloc(24);
    push_alloc(100);
    drain();
    blk = live_blocks;               // five live blocks, in heap order
    live_blocks.delete();
    push_free(blk[1]);               // both neighbors allocated
    push_free(blk[3]);               // both neighbors allocated
    push_free(blk[2]);               // both neighbors free
    push_free(blk[0]);               // next free, prev is the prologue
    push_free(blk[4]);               // both free, merges into the tail block
    push_alloc(65535);               // too big: out of memory
    push_alloc(4096);                // grows the heap by more than a page
    push_alloc(40000);
    drain();
    blk = live_blocks;
    live_blocks.delete();
    push_free(blk[0]);               // prev allocated, next allocated
    push_free(blk[1]);               // prev free, next free or allocated
    push_free(16'h0003);             // bogus: header falls outside the store
    push_free(blk[0]);               // double free of a merged block
    push_alloc(16);

    write_limit(17'h1FFFF);          // above the heap size: acts as full heap
    random_items(260);
    write_limit(17'd4096);           // one page: no further pages are mapped
    random_items(260);

    send_idle_pct = 57;
    recv_stall_pct = 14;
    write_limit(17'd12288);
    random_items(260);
    write_limit(17'd40000);
    random_items(260);

    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_limit(17'd65536);
    random_items(260);
    write_limit(17'd20480);
    random_items(250);

    drain();
    repeat (60) @(posedge clk);
    if (!failed) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog: clearing sweep plus worst-case walks and stalls, with headroom
  initial begin
    #(12 * 40000000);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
